/* src/efws_pkg.sv */
// efws_pkg: shared constants, types and key compare for the earliest-free
// worker scheduler. No dependencies; used by efws_core and the top level.
`timescale 1ns / 1ps

package efws_pkg;

   // worker count, field widths
   localparam int MAX_WORKERS = 64;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;
   localparam int TIME_W      = 48;
   localparam int DUR_W       = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // register index of active_workers, decoded from paddr[2]
   localparam logic REG_ACTIVE_WORKERS = 1'b0;

   localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(MAX_WORKERS);

   // control from the register block to the core
   typedef struct packed {
      logic             restart;
      logic [CNT_W-1:0] count;
   } cfg_type;

   // a zero count acts as one, an oversized count as the maximum
   function automatic logic [CNT_W-1:0] effective_count(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > CNT_W'(MAX_WORKERS)) begin
         r = CNT_W'(MAX_WORKERS);
      end
      return r;
   endfunction

   // true when worker a sits above worker b: earlier free time, then lower index
   function automatic logic key_less(input logic [TIME_W-1:0] ta, input logic [IDX_W-1:0] wa,
                                     input logic [TIME_W-1:0] tb, input logic [IDX_W-1:0] wb);
      logic r;
      if (ta != tb) begin
         r = ta < tb;
      end else begin
         r = wa < wb;
      end
      return r;
   endfunction

endpackage

/* src/earliest_free_worker_scheduler.sv */
// earliest_free_worker_scheduler: top level, register port and heap core.
// Depends on efws_pkg and efws_core.
`timescale 1ns / 1ps
//
//   channel   ports                              transfer
//   -------   --------------------------------   ---------------------------------
//   job in    start, busy, req_job_duration      edge with start high, busy low
//   result    rsp_valid, rsp_worker_index,       the single cycle rsp_valid is high
//             rsp_start_time
//   config    csr_psel/penable/pwrite/paddr/     access edge, pready tied high
//             pwdata/prdata/pready
//
// rsp_valid is registered in the charge state, after the root slot read and
// free-time read (S_LOADH, S_LOADF, S_LOADT). Each level of the heap sift-down
// takes two dependent RAM reads and a compare, plus a final read when the hole
// reaches a leaf; busy stays high for each job until its sift ends.
// A write of active_workers restarts a heapify of count/2 sift-downs, each a
// root load plus its sift; busy stays high throughout.
// Reset clears free times and sets 64 workers in identity order at once.
// The receiver cannot stall: each result is presented exactly one cycle.

module earliest_free_worker_scheduler (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [efws_pkg::DUR_W-1:0]             req_job_duration,
   output logic                                   rsp_valid,
   output logic [efws_pkg::IDX_W-1:0]             rsp_worker_index,
   output logic [efws_pkg::TIME_W-1:0]            rsp_start_time,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [efws_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [efws_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [efws_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   localparam int CW = efws_pkg::CNT_W;

   logic [CW-1:0]     active_ff;
   logic              csr_wr;
   logic              csr_hit;
   efws_pkg::cfg_type cfg;

   // register decode
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == efws_pkg::REG_ACTIVE_WORKERS;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;

   // active_workers register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= efws_pkg::ACTIVE_RESET;
      end else if (csr_wr) begin
         active_ff <= csr_pwdata[CW-1:0];
      end
   end

   // read back
   assign csr_prdata = csr_hit ? efws_pkg::CSR_DATA_W'(active_ff) : '0;

   // restart request toward the core
   assign cfg.restart = csr_wr;
   assign cfg.count   = efws_pkg::effective_count(csr_pwdata[CW-1:0]);

   efws_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .start            (start),
      .busy             (busy),
      .job_duration     (req_job_duration),
      .rsp_valid        (rsp_valid),
      .rsp_worker_index (rsp_worker_index),
      .rsp_start_time   (rsp_start_time)
   );

endmodule

/* src/efws_ram.sv */
// efws_ram: generic synchronous RAM, one write port and two read ports,
// read data registered. No dependencies.
`timescale 1ns / 1ps

module efws_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_a_addr,
   output logic [WIDTH-1:0] rd_a_data,
   input  logic [AW-1:0]    rd_b_addr,
   output logic [WIDTH-1:0] rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* src/efws_core.sv */
// efws_core: heap of workers keyed on (free time, index) held in two RAMs,
// with the sift-down sequencer. Depends on efws_pkg and efws_ram.
`timescale 1ns / 1ps

module efws_core (
   input  logic                                clock,
   input  logic                                reset,
   input  efws_pkg::cfg_type                   cfg,
   input  logic                                start,
   output logic                                busy,
   input  logic [efws_pkg::DUR_W-1:0]          job_duration,
   output logic                                rsp_valid,
   output logic [efws_pkg::IDX_W-1:0]          rsp_worker_index,
   output logic [efws_pkg::TIME_W-1:0]         rsp_start_time
);

   localparam int IW = efws_pkg::IDX_W;
   localparam int TW = efws_pkg::TIME_W;
   localparam int CW = efws_pkg::CNT_W;
   localparam int NW = efws_pkg::MAX_WORKERS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOADH,
      S_LOADF,
      S_LOADT,
      S_SIFT_RD,
      S_SIFT_KEY,
      S_SIFT_CMP
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         size_ff;
   logic [IW-1:0]         slot_ff;
   logic [IW-1:0]         base_ff;
   logic                  rebuild_ff;
   logic                  job_ff;
   logic [efws_pkg::DUR_W-1:0] dur_ff;
   logic [IW-1:0]         cur_w_ff;
   logic [TW-1:0]         cur_t_ff;
   logic                  hv_l_ff;
   logic                  hv_r_ff;
   logic                  fv_l_ff;
   logic                  fv_r_ff;
   logic [IW-1:0]         hl_w_ff;
   logic [IW-1:0]         hr_w_ff;
   logic [NW-1:0]         heap_valid_ff;
   logic [NW-1:0]         free_valid_ff;
   logic                  rsp_valid_ff;
   logic [IW-1:0]         rsp_worker_ff;
   logic [TW-1:0]         rsp_start_ff;

   // ram ports
   logic          heap_we;
   logic [IW-1:0] heap_waddr;
   logic [IW-1:0] heap_wdata;
   logic [IW-1:0] heap_ra;
   logic [IW-1:0] heap_rb;
   logic [IW-1:0] heap_da;
   logic [IW-1:0] heap_db;
   logic          free_we;
   logic [IW-1:0] free_waddr;
   logic [TW-1:0] free_wdata;
   logic [IW-1:0] free_ra;
   logic [IW-1:0] free_rb;
   logic [TW-1:0] free_da;
   logic [TW-1:0] free_db;

   // datapath
   logic [IW+1:0] l_slot;
   logic [IW+1:0] r_slot;
   logic          l_in;
   logic          r_in;
   logic [IW-1:0] w_load;
   logic [IW-1:0] w_left;
   logic [IW-1:0] w_right;
   logic [TW-1:0] t_a;
   logic [TW-1:0] t_b;
   logic [TW:0]   sum;
   logic [TW-1:0] sat;
   logic          lc;
   logic          rc;
   logic          rl;
   logic          pick_l;
   logic          pick_r;
   logic          sift_done;

   efws_ram #(.WIDTH(IW), .DEPTH(NW)) u_heap_ram (
      .clock     (clock),
      .wr_en     (heap_we),
      .wr_addr   (heap_waddr),
      .wr_data   (heap_wdata),
      .rd_a_addr (heap_ra),
      .rd_a_data (heap_da),
      .rd_b_addr (heap_rb),
      .rd_b_data (heap_db)
   );

   efws_ram #(.WIDTH(TW), .DEPTH(NW)) u_free_ram (
      .clock     (clock),
      .wr_en     (free_we),
      .wr_addr   (free_waddr),
      .wr_data   (free_wdata),
      .rd_a_addr (free_ra),
      .rd_a_data (free_da),
      .rd_b_addr (free_rb),
      .rd_b_data (free_db)
   );

   // children of the current hole
   assign l_slot = {1'b0, slot_ff, 1'b1};
   assign r_slot = l_slot + (IW+2)'(1);
   assign l_in   = l_slot < (IW+2)'(size_ff);
   assign r_in   = r_slot < (IW+2)'(size_ff);

   // unwritten heap slots hold the identity, unwritten free times read zero
   assign w_load  = hv_l_ff ? heap_da : slot_ff;
   assign w_left  = hv_l_ff ? heap_da : l_slot[IW-1:0];
   assign w_right = hv_r_ff ? heap_db : r_slot[IW-1:0];
   assign t_a     = fv_l_ff ? free_da : '0;
   assign t_b     = fv_r_ff ? free_db : '0;

   // read addresses
   assign heap_ra = (state_ff == S_SIFT_RD) ? l_slot[IW-1:0] : slot_ff;
   assign heap_rb = r_slot[IW-1:0];
   assign free_ra = (state_ff == S_LOADF) ? w_load : w_left;
   assign free_rb = w_right;

   // saturating free-time update
   assign sum = {1'b0, t_a} + (TW+1)'(dur_ff);
   assign sat = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

   // pick the smallest of hole, left and right
   assign lc = l_in && efws_pkg::key_less(t_a, hl_w_ff, cur_t_ff, cur_w_ff);
   assign rc = r_in && efws_pkg::key_less(t_b, hr_w_ff, cur_t_ff, cur_w_ff);
   assign rl = efws_pkg::key_less(t_b, hr_w_ff, t_a, hl_w_ff);
   assign pick_r = rc && (!lc || rl);
   assign pick_l = lc && !pick_r;

   assign sift_done = ((state_ff == S_SIFT_RD) && !l_in) ||
                      ((state_ff == S_SIFT_CMP) && !pick_l && !pick_r);

   // ram writes
   always_comb begin
      heap_we    = 1'b0;
      heap_waddr = slot_ff;
      heap_wdata = cur_w_ff;
      free_we    = 1'b0;
      free_waddr = cur_w_ff;
      free_wdata = sat;
      case (state_ff)
         S_SIFT_RD: begin
            heap_we = !l_in;
         end
         S_SIFT_CMP: begin
            heap_we = 1'b1;
            if (pick_r) begin
               heap_wdata = hr_w_ff;
            end else if (pick_l) begin
               heap_wdata = hl_w_ff;
            end
         end
         S_LOADT: begin
            free_we = job_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         size_ff       <= efws_pkg::ACTIVE_RESET;
         rebuild_ff    <= 1'b0;
         job_ff        <= 1'b0;
         heap_valid_ff <= '0;
         free_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (heap_we) begin
            heap_valid_ff[heap_waddr] <= 1'b1;
         end
         if (free_we) begin
            free_valid_ff[free_waddr] <= 1'b1;
         end

         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  slot_ff  <= '0;
                  job_ff   <= 1'b1;
                  dur_ff   <= job_duration;
                  state_ff <= S_LOADH;
               end
            end
            S_LOADH: begin
               hv_l_ff  <= heap_valid_ff[slot_ff];
               state_ff <= S_LOADF;
            end
            S_LOADF: begin
               cur_w_ff <= w_load;
               fv_l_ff  <= free_valid_ff[w_load];
               state_ff <= S_LOADT;
            end
            S_LOADT: begin
               if (job_ff) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_worker_ff <= cur_w_ff;
                  rsp_start_ff  <= t_a;
                  cur_t_ff      <= sat;
               end else begin
                  cur_t_ff <= t_a;
               end
               state_ff <= S_SIFT_RD;
            end
            S_SIFT_RD: begin
               hv_l_ff  <= heap_valid_ff[l_slot[IW-1:0]];
               hv_r_ff  <= heap_valid_ff[r_slot[IW-1:0]];
               state_ff <= l_in ? S_SIFT_KEY : S_IDLE;
            end
            S_SIFT_KEY: begin
               hl_w_ff  <= w_left;
               hr_w_ff  <= w_right;
               fv_l_ff  <= free_valid_ff[w_left];
               fv_r_ff  <= free_valid_ff[w_right];
               state_ff <= S_SIFT_CMP;
            end
            S_SIFT_CMP: begin
               if (pick_r) begin
                  slot_ff  <= r_slot[IW-1:0];
                  state_ff <= S_SIFT_RD;
               end else if (pick_l) begin
                  slot_ff  <= l_slot[IW-1:0];
                  state_ff <= S_SIFT_RD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // heapify continues with the next slot toward the root
         if (sift_done) begin
            job_ff <= 1'b0;
            if (rebuild_ff && (base_ff != '0)) begin
               base_ff  <= base_ff - IW'(1);
               slot_ff  <= base_ff - IW'(1);
               state_ff <= S_LOADH;
            end else begin
               rebuild_ff <= 1'b0;
               state_ff   <= S_IDLE;
            end
         end

         // register write: identity order, then heapify from the last parent
         if (cfg.restart) begin
            heap_valid_ff <= '0;
            size_ff       <= cfg.count;
            job_ff        <= 1'b0;
            if (cfg.count[CW-1:1] == '0) begin
               rebuild_ff <= 1'b0;
               state_ff   <= S_IDLE;
            end else begin
               rebuild_ff <= 1'b1;
               base_ff    <= IW'(cfg.count[CW-1:1] - (CW-1)'(1));
               slot_ff    <= IW'(cfg.count[CW-1:1] - (CW-1)'(1));
               state_ff   <= S_LOADH;
            end
         end
      end
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_worker_index = rsp_worker_ff;
   assign rsp_start_time   = rsp_start_ff;

`ifndef SYNTHESIS
   // a result only follows the load of a job's root
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_LOADT && job_ff))
      else $error("result without a job load");

   // an accepted job starts by reading the root
   a_start_loads_root: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !cfg.restart) |=> (state_ff == S_LOADH && slot_ff == '0 && job_ff))
      else $error("accepted job did not read the root");

   // the hole never leaves the active heap
   a_hole_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SIFT_RD) |-> (CW'(slot_ff) < size_ff))
      else $error("sift hole outside the heap");

   // free times change only while a job is being charged
   a_free_write_job: assert property (@(posedge clock) disable iff (reset)
      free_we |-> (state_ff == S_LOADT && job_ff && !rebuild_ff))
      else $error("free time written outside a job");

   // the assigned worker is always an active one
   a_worker_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CW'(rsp_worker_index) < size_ff))
      else $error("inactive worker assigned");
`endif

endmodule
